// ===== sv/asv_pkg.sv =====
// shared types, constants and the division step for the arrive steering pipeline
package asv_pkg;

    localparam int DataW   = 32;
    localparam int RegW    = 31;
    localparam int CfgIdxW = 2;
    localparam int Lanes   = 3;
    localparam int MagW    = 33;
    localparam int SqW     = 2 * MagW;
    localparam int RadW    = 66;
    localparam int RootW   = 33;
    localparam int RemW    = RootW + 2;
    localparam int SqSteps = RadW / 2;
    localparam int QuoW    = 31;
    localparam int DvW     = 33;
    localparam int DivSteps = QuoW;
    localparam int HalfW   = 16;
    localparam int PartW   = HalfW + RegW;
    localparam int PmW     = PartW + 1;

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_ARRIVE_RADIUS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED     = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WEIGHT        = 2'd2;

    // register reset values
    localparam logic [RegW-1:0] RST_ARRIVE_RADIUS = 31'd327680;
    localparam logic [RegW-1:0] RST_MAX_SPEED     = 31'd655360;
    localparam logic [RegW-1:0] RST_WEIGHT        = 31'd65536;

    // output clamp limits
    localparam logic [DataW-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] SAT_MIN = 32'h8000_0000;
    localparam logic [PmW-1:0]   POS_LIM = PmW'(32'h7FFF_FFFF);
    localparam logic [PmW-1:0]   NEG_LIM = PmW'(33'h1_0000_0000 >> 1);

    typedef struct packed {
        logic signed [DataW-1:0] target_x;
        logic signed [DataW-1:0] target_y;
        logic signed [DataW-1:0] target_z;
        logic signed [DataW-1:0] agent_x;
        logic signed [DataW-1:0] agent_y;
        logic signed [DataW-1:0] agent_z;
        logic signed [DataW-1:0] cur_vx;
        logic signed [DataW-1:0] cur_vy;
        logic signed [DataW-1:0] cur_vz;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0] new_vx;
        logic signed [DataW-1:0] new_vy;
        logic signed [DataW-1:0] new_vz;
        logic                    saturated;
    } t_out_item;

    // per-item data carried down the pipeline
    typedef struct packed {
        logic [Lanes-1:0][MagW-1:0]  mag;
        logic [Lanes-1:0]            neg;
        logic [Lanes-1:0][DataW-1:0] cur;
        logic                        zero;
    } t_vec_pay;

    typedef struct packed {
        logic [RadW-1:0]  rad;
        logic [RemW-1:0]  rem;
        logic [RootW-1:0] root;
        t_vec_pay         pay;
    } t_sq_st;

    typedef struct packed {
        logic [DvW-1:0]   rem;
        logic [QuoW-1:0]  sh;
        logic [RootW-1:0] d;
        logic             fast;
        t_vec_pay         pay;
    } t_spd_st;

    typedef struct packed {
        logic [Lanes-1:0][DvW-1:0]  rem;
        logic [Lanes-1:0][QuoW-1:0] sh;
        logic [RootW-1:0]           d;
        logic [QuoW-1:0]            speed;
        t_vec_pay                   pay;
    } t_vd_st;

    typedef struct packed {
        logic [DvW-1:0]  rem;
        logic [QuoW-1:0] sh;
    } t_div_res;

    // one restoring division step: dividend bit shifts out, quotient bit shifts in
    function automatic t_div_res div_step(logic [DvW-1:0] rem, logic [QuoW-1:0] sh,
                                          logic [DvW-1:0] dv);
        t_div_res   r;
        logic [DvW:0] t;
        t = {rem, sh[QuoW-1]};
        if (t >= {1'b0, dv}) begin
            r.rem = DvW'(t - {1'b0, dv});
            r.sh  = {sh[QuoW-2:0], 1'b1};
        end else begin
            r.rem = t[DvW-1:0];
            r.sh  = {sh[QuoW-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== sv/asv_sqrt_cell.sv =====
// one digit cell of the pipelined square root
module asv_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  asv_pkg::t_sq_st i_st,
    output logic            o_vld,
    output asv_pkg::t_sq_st o_st
);
    import asv_pkg::*;

    logic [RemW+1:0] t;
    logic [RemW+1:0] trial;
    t_sq_st          n_st;
    t_sq_st          r_st;
    logic            r_vld;

    // bring in two radicand bits and try the next root bit
    always_comb begin
        n_st       = i_st;
        t          = {i_st.rem, i_st.rad[RadW-1 -: 2]};
        trial      = {2'b00, i_st.root, 2'b01};
        n_st.rad   = {i_st.rad[RadW-3:0], 2'b00};
        if (t >= trial) begin
            n_st.rem  = RemW'(t - trial);
            n_st.root = {i_st.root[RootW-2:0], 1'b1};
        end else begin
            n_st.rem  = t[RemW-1:0];
            n_st.root = {i_st.root[RootW-2:0], 1'b0};
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // cell state
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ===== sv/asv_spd_cell.sv =====
// one quotient-bit cell of the speed divider
module asv_spd_cell (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic [asv_pkg::DvW-1:0] i_dv,
    input  logic                    i_vld,
    input  asv_pkg::t_spd_st        i_st,
    output logic                    o_vld,
    output asv_pkg::t_spd_st        o_st
);
    import asv_pkg::*;

    t_spd_st  n_st;
    t_spd_st  r_st;
    t_div_res res;
    logic     r_vld;

    // one step against the slowing radius
    always_comb begin
        n_st     = i_st;
        res      = div_step(i_st.rem, i_st.sh, i_dv);
        n_st.rem = res.rem;
        n_st.sh  = res.sh;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // cell state
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ===== sv/asv_vdiv_cell.sv =====
// one quotient-bit cell of the three-lane direction divider
module asv_vdiv_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  asv_pkg::t_vd_st i_st,
    output logic            o_vld,
    output asv_pkg::t_vd_st o_st
);
    import asv_pkg::*;

    t_vd_st   n_st;
    t_vd_st   r_st;
    t_div_res res [Lanes];
    logic     r_vld;

    // each lane divides by the distance
    always_comb begin
        n_st = i_st;
        for (int i = 0; i < Lanes; i++) begin
            res[i]      = div_step(i_st.rem[i], i_st.sh[i], i_st.d);
            n_st.rem[i] = res[i].rem;
            n_st.sh[i]  = res[i].sh;
        end
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    // cell state
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_vld = r_vld;
    assign o_st  = r_st;

endmodule

// ===== sv/arrive_steering_velocity.sv =====
// arrive steering: one agent update per cycle unless the output stalls, fully pipelined over
// 103 stages. The depth comes from the square-root cell row (33 cells), the speed divider row
// (31 cells) and the direction divider row (31 cells, three lanes), plus front, multiply and
// clamp stages. The whole pipeline advances together; it stalls only while a result waits at
// the output. Configuration writes are always taken and should be made while no transaction
// is in flight.
module arrive_steering_velocity (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  asv_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output asv_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [asv_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [asv_pkg::DataW-1:0]   i_cfg_data
);
    import asv_pkg::*;

    logic            en;
    logic [RegW-1:0] r_radius;
    logic [RegW-1:0] r_max_speed;
    logic [RegW-1:0] r_weight;

    // front stages
    logic                      r_f_vld, r_q_vld, r_s_vld;
    t_vec_pay                  r_f_pay, r_q_pay, r_s_pay;
    t_vec_pay                  n_f_pay;
    logic [Lanes-1:0][SqW-1:0] r_q_sq;
    logic [RadW-1:0]           r_s_rad;
    logic signed [MagW-1:0]    off [Lanes];

    // cell rows
    t_sq_st  sq_st  [SqSteps+1];
    logic    sq_vld [SqSteps+1];
    t_spd_st spd_st [DivSteps+1];
    logic    spd_vld[DivSteps+1];
    t_vd_st  vd_st  [DivSteps+1];
    logic    vd_vld [DivSteps+1];

    logic                    in_rng;
    logic [2*RegW-1:0]       spd_prod;
    t_spd_st                 n_spd;
    logic [QuoW-1:0]         speed;
    logic [Lanes-1:0][63:0]  dir_prod;
    t_vd_st                  n_vd;

    // back stages
    logic                         r_w1_vld, r_w2_vld, r_out_vld;
    logic                         r_w1_zero, r_w2_zero;
    logic [Lanes-1:0]             r_w1_neg, r_w2_neg;
    logic [Lanes-1:0][DataW-1:0]  r_w1_mag;
    logic [Lanes-1:0][PartW-1:0]  r_w2_lo, r_w2_hi;
    logic signed [DataW+1:0]      wanted [Lanes];
    logic signed [DataW+1:0]      diff   [Lanes];
    logic [PmW-1:0]               pm     [Lanes];
    logic [Lanes-1:0][DataW-1:0]  res;
    logic [Lanes-1:0]             sat;
    t_out_item                    r_out;
    t_out_item                    n_out;

    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RST_ARRIVE_RADIUS;
            r_max_speed <= RST_MAX_SPEED;
            r_weight    <= RST_WEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ARRIVE_RADIUS: r_radius    <= i_cfg_data[RegW-1:0];
                CFG_MAX_SPEED:     r_max_speed <= i_cfg_data[RegW-1:0];
                CFG_WEIGHT:        r_weight    <= i_cfg_data[RegW-1:0];
                default:           ;
            endcase
        end
    end

    // offset magnitudes and signs
    always_comb begin
        off[0] = {i_in_data.target_x[DataW-1], i_in_data.target_x}
               - {i_in_data.agent_x[DataW-1], i_in_data.agent_x};
        off[1] = {i_in_data.target_y[DataW-1], i_in_data.target_y}
               - {i_in_data.agent_y[DataW-1], i_in_data.agent_y};
        off[2] = {i_in_data.target_z[DataW-1], i_in_data.target_z}
               - {i_in_data.agent_z[DataW-1], i_in_data.agent_z};
        n_f_pay.cur[0] = i_in_data.cur_vx;
        n_f_pay.cur[1] = i_in_data.cur_vy;
        n_f_pay.cur[2] = i_in_data.cur_vz;
        for (int i = 0; i < Lanes; i++) begin
            n_f_pay.neg[i] = off[i][MagW-1];
            n_f_pay.mag[i] = off[i][MagW-1] ? MagW'(-off[i]) : MagW'(off[i]);
        end
        n_f_pay.zero = (off[0] == '0) && (off[1] == '0) && (off[2] == '0);
    end

    // front valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_q_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_f_vld <= i_in_valid;
            r_q_vld <= r_f_vld;
            r_s_vld <= r_q_vld;
        end
    end

    // offset, squares, sum of squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_pay <= n_f_pay;
            r_q_pay <= r_f_pay;
            for (int i = 0; i < Lanes; i++) begin
                r_q_sq[i] <= r_f_pay.mag[i] * r_f_pay.mag[i];
            end
            r_s_pay <= r_q_pay;
            r_s_rad <= RadW'(r_q_sq[0]) + RadW'(r_q_sq[1]) + RadW'(r_q_sq[2]);
        end
    end

    // square root cell row
    assign sq_vld[0]      = r_s_vld;
    assign sq_st[0].rad   = r_s_rad;
    assign sq_st[0].rem   = '0;
    assign sq_st[0].root  = '0;
    assign sq_st[0].pay   = r_s_pay;

    for (genvar k = 0; k < SqSteps; k++) begin : g_sq
        asv_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (sq_vld[k]),
            .i_st    (sq_st[k]),
            .o_vld   (sq_vld[k+1]),
            .o_st    (sq_st[k+1])
        );
    end

    // max_speed * distance, only needed inside the slowing radius
    always_comb begin
        in_rng     = (r_radius != '0) && (sq_st[SqSteps].root < {2'b00, r_radius});
        spd_prod   = r_max_speed * sq_st[SqSteps].root[RegW-1:0];
        n_spd.rem  = in_rng ? {2'b00, spd_prod[2*RegW-1:QuoW]} : '0;
        n_spd.sh   = in_rng ? spd_prod[QuoW-1:0] : '0;
        n_spd.d    = sq_st[SqSteps].root;
        n_spd.fast = !in_rng;
        n_spd.pay  = sq_st[SqSteps].pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            spd_vld[0] <= 1'b0;
        end else if (en) begin
            spd_vld[0] <= sq_vld[SqSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            spd_st[0] <= n_spd;
        end
    end

    // speed divider cell row
    for (genvar k = 0; k < DivSteps; k++) begin : g_spd
        asv_spd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_dv    ({2'b00, r_radius}),
            .i_vld   (spd_vld[k]),
            .i_st    (spd_st[k]),
            .o_vld   (spd_vld[k+1]),
            .o_st    (spd_st[k+1])
        );
    end

    // offset magnitude * speed per lane
    always_comb begin
        speed = spd_st[DivSteps].fast ? r_max_speed : spd_st[DivSteps].sh;
        for (int i = 0; i < Lanes; i++) begin
            dir_prod[i]  = spd_st[DivSteps].pay.mag[i] * speed;
            n_vd.rem[i]  = {1'b0, dir_prod[i][62:QuoW]};
            n_vd.sh[i]   = dir_prod[i][QuoW-1:0];
        end
        n_vd.d     = spd_st[DivSteps].d;
        n_vd.speed = speed;
        n_vd.pay   = spd_st[DivSteps].pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            vd_vld[0] <= 1'b0;
        end else if (en) begin
            vd_vld[0] <= spd_vld[DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            vd_st[0] <= n_vd;
        end
    end

    // direction divider cell row
    for (genvar k = 0; k < DivSteps; k++) begin : g_vd
        asv_vdiv_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (vd_vld[k]),
            .i_st    (vd_st[k]),
            .o_vld   (vd_vld[k+1]),
            .o_st    (vd_st[k+1])
        );
    end

    // wanted minus current velocity
    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            wanted[i] = vd_st[DivSteps].pay.neg[i]
                      ? -$signed({3'b000, vd_st[DivSteps].sh[i]})
                      :  $signed({3'b000, vd_st[DivSteps].sh[i]});
            diff[i]   = wanted[i] - $signed({{2{vd_st[DivSteps].pay.cur[i][DataW-1]}},
                                             vd_st[DivSteps].pay.cur[i]});
        end
    end

    // weight partial products and clamp
    always_comb begin
        for (int i = 0; i < Lanes; i++) begin
            pm[i] = PmW'(r_w2_hi[i]) + PmW'(r_w2_lo[i] >> HalfW);
            if (r_w2_neg[i]) begin
                sat[i] = pm[i] > NEG_LIM;
                res[i] = sat[i] ? SAT_MIN : DataW'(-pm[i][DataW-1:0]);
            end else begin
                sat[i] = pm[i] > POS_LIM;
                res[i] = sat[i] ? SAT_MAX : pm[i][DataW-1:0];
            end
        end
        if (r_w2_zero) begin
            n_out = '0;
        end else begin
            n_out.new_vx    = res[0];
            n_out.new_vy    = res[1];
            n_out.new_vz    = res[2];
            n_out.saturated = |sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_vld  <= 1'b0;
            r_w2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_w1_vld  <= vd_vld[DivSteps];
            r_w2_vld  <= r_w1_vld;
            r_out_vld <= r_w2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w1_zero <= vd_st[DivSteps].pay.zero;
            for (int i = 0; i < Lanes; i++) begin
                r_w1_neg[i] <= diff[i][DataW+1];
                r_w1_mag[i] <= diff[i][DataW+1] ? DataW'(-diff[i]) : DataW'(diff[i]);
                r_w2_lo[i]  <= r_w1_mag[i][HalfW-1:0] * r_weight;
                r_w2_hi[i]  <= r_w1_mag[i][DataW-1:HalfW] * r_weight;
            end
            r_w2_neg  <= r_w1_neg;
            r_w2_zero <= r_w1_zero;
            r_out     <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // checks
    a_sat_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.saturated) |->
        (r_out.new_vx == SAT_MAX || r_out.new_vx == SAT_MIN ||
         r_out.new_vy == SAT_MAX || r_out.new_vy == SAT_MIN ||
         r_out.new_vz == SAT_MAX || r_out.new_vz == SAT_MIN))
        else $error("saturated flag without a clamped component");

    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sq_vld[SqSteps] && sq_st[SqSteps].pay.zero) |-> (sq_st[SqSteps].root == '0))
        else $error("zero offset gave a nonzero distance");

    a_speed_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        spd_vld[DivSteps] |-> (speed <= r_max_speed))
        else $error("speed above cap");

    a_dir_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (vd_vld[DivSteps] && !vd_st[DivSteps].pay.zero) |->
        (vd_st[DivSteps].sh[0] <= vd_st[DivSteps].speed &&
         vd_st[DivSteps].sh[1] <= vd_st[DivSteps].speed &&
         vd_st[DivSteps].sh[2] <= vd_st[DivSteps].speed))
        else $error("wanted velocity component above speed");

endmodule

// ===== dv/tb_arrive_steering_velocity.sv =====
// testbench for the arrive steering pipeline: directed table, then random phases
`timescale 1ns / 100ps

module tb_arrive_steering_velocity;
    import asv_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
    localparam int PipeDepth  = 103;
    localparam int CycleLimit = 1000000;
    localparam int PhaseItems = 300;

    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DataW-1:0]   cfg_data = '0;

    // shadow registers
    logic [RegW-1:0] radius_q = RST_ARRIVE_RADIUS;
    logic [RegW-1:0] speed_cap_q = RST_MAX_SPEED;
    logic [RegW-1:0] weight_q = RST_WEIGHT;

    t_out_item pending_vel[$];
    int  fails = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  hold_left = 0;
    longint cycles = 0;

    arrive_steering_velocity u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout at %0t", $time);
            $display("** arrive_steering_velocity: FAILED **");
            $finish;
        end
    end

    // expected new velocity for one agent under the current registers
    function automatic t_out_item predict_velocity(t_in_item it);
        longint    tgt[3], agt[3], cur[3], offs[3];
        logic [127:0] mag[3];
        logic [127:0] sum, root, cand, spd, wm, pm;
        longint    wanted, diff;
        logic [63:0] dmag;
        logic [DataW-1:0] lane[3];
        bit        sat;
        t_out_item r;
        tgt = '{longint'(it.target_x), longint'(it.target_y), longint'(it.target_z)};
        agt = '{longint'(it.agent_x), longint'(it.agent_y), longint'(it.agent_z)};
        cur = '{longint'(it.cur_vx), longint'(it.cur_vy), longint'(it.cur_vz)};
        sum = '0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            offs[i] = tgt[i] - agt[i];
            mag[i] = offs[i] < 0 ? 128'(-offs[i]) : 128'(offs[i]);
            sum += mag[i] * mag[i];
        end
        if (sum == 0) return '0;
        // integer square root, bit by bit
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sum) root = cand;
        end
        // speed ramps up inside the radius
        if (radius_q == 0) spd = 128'(speed_cap_q);
        else begin
            spd = (128'(speed_cap_q) * root) / 128'(radius_q);
            if (spd > 128'(speed_cap_q)) spd = 128'(speed_cap_q);
        end
        for (int i = 0; i < 3; i++) begin
            wm = (mag[i] * spd) / root;
            wanted = offs[i] < 0 ? -longint'(wm) : longint'(wm);
            diff = wanted - cur[i];
            dmag = diff < 0 ? 64'(-diff) : 64'(diff);
            pm = (128'(dmag) * 128'(weight_q)) >> 16;
            if (diff < 0) begin
                if (pm > 128'h8000_0000) begin
                    pm = 128'h8000_0000;
                    sat = 1'b1;
                end
                lane[i] = DataW'(-pm);
            end else begin
                if (pm > 128'h7FFF_FFFF) begin
                    pm = 128'h7FFF_FFFF;
                    sat = 1'b1;
                end
                lane[i] = DataW'(pm);
            end
        end
        r.new_vx = lane[0];
        r.new_vy = lane[1];
        r.new_vz = lane[2];
        r.saturated = sat;
        return r;
    endfunction

    // receiver readiness: long hold-off first, else random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic report_field(string name, logic [DataW-1:0] exp, logic [DataW-1:0] act);
        if (exp !== act) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
            fails++;
        end
    endtask

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_vel.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, out_data);
                fails++;
            end else begin
                e = pending_vel.pop_front();
                report_field("new_vx", e.new_vx, out_data.new_vx);
                report_field("new_vy", e.new_vy, out_data.new_vy);
                report_field("new_vz", e.new_vz, out_data.new_vz);
                report_field("saturated", DataW'(e.saturated), DataW'(out_data.saturated));
            end
        end
    end

    // offer one input transaction, record its expectation on acceptance
    task automatic send_agent(t_in_item it, bit known, t_out_item exp);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (!in_ready);
        pending_vel.push_back(known ? exp : predict_velocity(it));
        @(negedge i_clk);
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        wait (pending_vel.size() == 0);
        repeat (PipeDepth + 8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_ARRIVE_RADIUS: radius_q = val[RegW-1:0];
            CFG_MAX_SPEED:     speed_cap_q = val[RegW-1:0];
            CFG_WEIGHT:        weight_q = val[RegW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [DataW-1:0] pick_edge();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // random agent: mostly near the target, some wide, edge and zero offsets
    function automatic t_in_item rand_agent();
        t_in_item it;
        int sel;
        int span;
        sel = $urandom_range(99);
        span = $urandom_range(8, 24);
        it.agent_x = $urandom;
        it.agent_y = $urandom;
        it.agent_z = $urandom;
        it.cur_vx = $urandom_range(1) ? $urandom : $signed($urandom_range(1 << 21)) - (1 << 20);
        it.cur_vy = $urandom_range(1) ? $urandom : $signed($urandom_range(1 << 21)) - (1 << 20);
        it.cur_vz = $urandom_range(1) ? $urandom : $signed($urandom_range(1 << 21)) - (1 << 20);
        if (sel < 55) begin
            it.target_x = it.agent_x + ($signed($urandom) >>> (32 - span));
            it.target_y = it.agent_y + ($signed($urandom) >>> (32 - span));
            it.target_z = it.agent_z + ($signed($urandom) >>> (32 - span));
        end else if (sel < 80) begin
            it.target_x = $urandom;
            it.target_y = $urandom;
            it.target_z = $urandom;
        end else if (sel < 93) begin
            it.target_x = pick_edge();
            it.target_y = pick_edge();
            it.target_z = pick_edge();
            it.agent_x = pick_edge();
            it.agent_y = pick_edge();
            it.agent_z = pick_edge();
            it.cur_vx = pick_edge();
        end else begin
            it.target_x = it.agent_x;
            it.target_y = it.agent_y;
            it.target_z = it.agent_z;
        end
        return it;
    endfunction

    function automatic t_in_item mk(int tx, int ty, int tz, int ax, int ay, int az,
                                    int vx, int vy, int vz);
        return '{tx, ty, tz, ax, ay, az, vx, vy, vz};
    endfunction

    initial begin
        t_row rows[$];
        t_out_item none;
        none = '0;

        // directed rows: known answers only where obvious
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
        rows.push_back('{mk(5, 5, 5, 5, 5, 5, 32'h7FFF_FFFF, -1, 32'h8000_0000), 1'b1, '0});
        rows.push_back('{mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 123, 456, 789), 1'b1, '0});
        rows.push_back('{mk(32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(32'h000A_0000, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{32'h000A_0000, 0, 0, 1'b0}});
        rows.push_back('{mk(0, 32'hFFF6_0000, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                         '{0, 32'hFFF6_0000, 0, 1'b0}});
        rows.push_back('{mk(0, 0, 32'h0002_0000, 0, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                            0, 32'h7FFF_FFFF, 32'h8000_0000, 0), 1'b0, none});
        rows.push_back('{mk(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -1), 1'b1, '0});
        rows.push_back('{mk(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{mk(32'h0100_0000, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0), 1'b0, none});
        rows.push_back('{mk(32'hFF00_0000, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0), 1'b0, none});
        rows.push_back('{mk(-1, -1, -1, 0, 0, 0, 1, 1, 1), 1'b0, none});

        // reset
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) send_agent(rows[k].item, rows[k].known, rows[k].exp);
        drain_pipe();

        // saturation with a heavy weight on the same rows
        cfg_write(CFG_WEIGHT, 32'hFFFF_FFFF);
        foreach (rows[k]) send_agent(rows[k].item, 1'b0, none);
        drain_pipe();

        // random phases over several register settings and idling modes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_ARRIVE_RADIUS, 32'd1);
                    cfg_write(CFG_MAX_SPEED, 32'h7FFF_FFFF);
                    cfg_write(CFG_WEIGHT, 32'h7FFF_FFFF);
                end
                1: begin
                    cfg_write(CFG_ARRIVE_RADIUS, 32'h7FFF_FFFF);
                    cfg_write(CFG_MAX_SPEED, 32'd1);
                    cfg_write(CFG_WEIGHT, 32'h0001_0000);
                end
                2: begin
                    // top bit masked off, radius becomes zero
                    cfg_write(CFG_ARRIVE_RADIUS, 32'h8000_0000);
                    cfg_write(CFG_MAX_SPEED, 32'h000A_0000);
                    cfg_write(CFG_WEIGHT, 32'd0);
                    cfg_write(CFG_SPARE, 32'h1234_5678);
                end
                3: begin
                    cfg_write(CFG_ARRIVE_RADIUS, 32'h0001_0000);
                    cfg_write(CFG_MAX_SPEED, 32'd0);
                    cfg_write(CFG_WEIGHT, 32'h0002_0000);
                end
                4: begin
                    cfg_write(CFG_ARRIVE_RADIUS, RST_ARRIVE_RADIUS);
                    cfg_write(CFG_MAX_SPEED, RST_MAX_SPEED);
                    cfg_write(CFG_WEIGHT, RST_WEIGHT);
                end
                default: begin
                    cfg_write(CFG_ARRIVE_RADIUS, $urandom_range(1, 32'h00FF_FFFF));
                    cfg_write(CFG_MAX_SPEED, $urandom);
                    cfg_write(CFG_WEIGHT, $urandom_range(0, 32'h0004_0000));
                end
            endcase
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                // long receiver hold-off so the pipe fills and backs up
                if (ph == 0 && n == 20) begin
                    in_valid <= 1'b0;
                    @(posedge i_clk);
                    hold_left = 400;
                    @(negedge i_clk);
                end
                // sender waits for every outstanding result
                if (ph == 4 && n == PhaseItems / 2) begin
                    in_valid <= 1'b0;
                    wait (pending_vel.size() == 0);
                    @(negedge i_clk);
                end
                send_agent(rand_agent(), 1'b0, none);
            end
            drain_pipe();
        end

        idle_pct = 0;
        stall_pct = 0;
        wait (pending_vel.size() == 0);
        repeat (PipeDepth + 20) @(posedge i_clk);
        if (fails == 0 && pending_vel.size() == 0) begin
            $display("** arrive_steering_velocity: PASSED **");
        end else begin
            $display("** arrive_steering_velocity: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/asv_pkg.sv
sv/asv_sqrt_cell.sv
sv/asv_spd_cell.sv
sv/asv_vdiv_cell.sv
sv/arrive_steering_velocity.sv
dv/tb_arrive_steering_velocity.sv
